>>> hdl/fds_pkg.sv
// Shared types and constants of the frame deadline scheduler.
`default_nettype none
package fds_pkg;

   localparam int TIME_W = 64;
   localparam logic [TIME_W-1:0] IDX_MAX = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      ALU_MUL = 2'b01,
      ALU_DIV = 2'b10
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_req_type;

   // mul: product = {hi, lo}; div: quotient in lo, remainder in hi
   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] hi;
      logic [TIME_W-1:0] lo;
   } alu_rsp_type;

   typedef enum logic [1:0] {
      CSR_TARGET_EN = 2'd0,
      CSR_WHOLE     = 2'd1,
      CSR_NUM       = 2'd2,
      CSR_DEN       = 2'd3
   } csr_index_type;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_WAIT     = 14'b00000000000010,
      ST_FIX_RES  = 14'b00000000000100,
      ST_EV_A     = 14'b00000000001000,
      ST_EV_B     = 14'b00000000010000,
      ST_EV_C     = 14'b00000000100000,
      ST_EV_D     = 14'b00000001000000,
      ST_EV_E     = 14'b00000010000000,
      ST_MAIN_RES = 14'b00000100000000,
      ST_EXP_CHK  = 14'b00001000000000,
      ST_EXP_RES  = 14'b00010000000000,
      ST_BIN_CHK  = 14'b00100000000000,
      ST_BIN_RES  = 14'b01000000000000,
      ST_OUT      = 14'b10000000000000
   } state_type;

endpackage
`default_nettype wire

>>> hdl/fds_alu.sv
// Bit-serial 64-bit multiplier / restoring divider, one bit per cycle.
`default_nettype none
module fds_alu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fds_pkg::alu_req_type req,
   output fds_pkg::alu_rsp_type      rsp
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [5:0]                   cnt_ff;
   fds_pkg::alu_op_type          op_ff;
   logic [fds_pkg::TIME_W-1:0]   a_ff;
   logic [fds_pkg::TIME_W-1:0]   hi_ff;
   logic [fds_pkg::TIME_W-1:0]   lo_ff;

   logic [fds_pkg::TIME_W:0]     msum;
   logic [fds_pkg::TIME_W:0]     dsh;
   logic [fds_pkg::TIME_W+1:0]   dtry;

   assign msum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
   assign dsh  = {hi_ff, lo_ff[fds_pkg::TIME_W-1]};
   assign dtry = {1'b0, dsh} - {2'b00, a_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= fds_pkg::ALU_MUL;
      end else begin
         done_ff <= 1'b0;
         if (req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            op_ff   <= req.op;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start && !busy_ff) begin
         hi_ff <= '0;
         if (req.op == fds_pkg::ALU_MUL) begin
            a_ff  <= req.a;
            lo_ff <= req.b;
         end else begin
            a_ff  <= req.b;
            lo_ff <= req.a;
         end
      end else if (busy_ff) begin
         if (op_ff == fds_pkg::ALU_MUL) begin
            hi_ff <= msum[fds_pkg::TIME_W:1];
            lo_ff <= {msum[0], lo_ff[fds_pkg::TIME_W-1:1]};
         end else begin
            hi_ff <= dtry[fds_pkg::TIME_W+1] ? dsh[fds_pkg::TIME_W-1:0]
                                              : dtry[fds_pkg::TIME_W-1:0];
            lo_ff <= {lo_ff[fds_pkg::TIME_W-2:0], ~dtry[fds_pkg::TIME_W+1]};
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.hi   = hi_ff;
   assign rsp.lo   = lo_ff;

endmodule
`default_nettype wire

>>> hdl/frame_deadline_scheduler.sv
// Frame deadline scheduler: sequencer around a shared serial mul/div unit.
//
//  channel | direction | handshake             | contents
//  req     | in        | req_tvalid/req_tready | frame request, times and fixed-step data
//  rsp     | out       | rsp_tvalid/rsp_tready | deadline flag and deadline time
//  csr     | in        | csr_we                | period and target-enable registers
//
// Every mul or div runs on the one shared unit. A fixed-step request uses at most
// one multiply; a target request one evaluation (5 ops), and a missed deadline up
// to ~128 more evaluations. Reset is synchronous; req_tready is high only in idle.
// A result waits in the output register until taken and the next request is
// accepted meanwhile.
`default_nettype none
module frame_deadline_scheduler (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // frame start time, now, step length, frame count, app start time
   input  wire logic [319:0] req_tdata,
   // has_fixed_step, pace_fixed_step
   input  wire logic [1:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // deadline_ns
   output      logic [63:0]  rsp_tdata,
   // deadline_valid
   output      logic [0:0]   rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [62:0]  csr_wdata
);

   localparam int W = fds_pkg::TIME_W;

   fds_pkg::state_type   state_ff, ret_ff, evret_ff;
   fds_pkg::alu_req_type alu_req;
   fds_pkg::alu_rsp_type alu_rsp;

   logic          target_ff;
   logic [62:0]   whole_ff;
   logic [29:0]   num_ff;
   logic [30:0]   den_ff;
   logic          started_ff;
   logic [W-1:0]  origin_ff;
   logic [W-1:0]  next_idx_ff;

   logic [W-1:0]  now_ff, app_ff;
   logic [W-1:0]  ev_idx_ff, o_ff, r_ff;
   logic          ev_ok_ff;
   logic [W-1:0]  ev_dl_ff;
   logic [W-1:0]  lo_ff, hi_ff, stp_ff, mid_ff;
   logic          res_valid_ff;
   logic [W-1:0]  res_dl_ff;
   logic          rsp_valid_ff;
   logic [W-1:0]  rsp_dl_ff;
   logic          rsp_flag_ff;

   logic [W-1:0]  den_eff, whole_ext, num_ext;
   logic [W:0]    exp_sum;
   logic [W-1:0]  hi_calc, span, mid_calc;
   logic [W:0]    add_o;
   logic [W:0]    org_sum;
   logic [W:0]    fix_sum;
   logic          accept, take_out;

   assign den_eff   = (den_ff == '0) ? W'(1) : {{(W-31){1'b0}}, den_ff};
   assign whole_ext = {1'b0, whole_ff};
   assign num_ext   = {{(W-30){1'b0}}, num_ff};
   assign exp_sum   = {1'b0, lo_ff} + {1'b0, stp_ff};
   assign hi_calc   = exp_sum[W] ? fds_pkg::IDX_MAX : exp_sum[W-1:0];
   assign span      = hi_ff - lo_ff;
   assign mid_calc  = lo_ff + {1'b0, span[W-1:1]};
   // running offset plus the latest partial result (mul low word or quotient)
   assign add_o     = {1'b0, o_ff} + {1'b0, alu_rsp.lo};
   assign org_sum   = {origin_ff[W-1], origin_ff} + {1'b0, add_o[W-1:0]};
   assign fix_sum   = {app_ff[W-1], app_ff} + {1'b0, alu_rsp.lo};

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == fds_pkg::ST_IDLE);
   assign take_out   = !rsp_valid_ff || rsp_tready;

   fds_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   always_comb begin
      alu_req.start = 1'b0;
      alu_req.op    = fds_pkg::ALU_MUL;
      alu_req.a     = alu_rsp.lo;
      alu_req.b     = num_ext;
      unique case (state_ff)
         fds_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0]) begin
                  alu_req.start = req_tuser[1];
                  alu_req.a     = req_tdata[191:128];
                  alu_req.b     = req_tdata[255:192];
               end else if (target_ff) begin
                  alu_req.start = 1'b1;
                  alu_req.a     = next_idx_ff;
                  alu_req.b     = whole_ext;
               end
            end
         end
         fds_pkg::ST_EV_A: begin
            alu_req.start = (alu_rsp.hi == '0) && !alu_rsp.lo[W-1];
            alu_req.op    = fds_pkg::ALU_DIV;
            alu_req.a     = ev_idx_ff;
            alu_req.b     = den_eff;
         end
         fds_pkg::ST_EV_B: begin
            alu_req.start = 1'b1;
         end
         fds_pkg::ST_EV_C: begin
            alu_req.start = (alu_rsp.hi == '0) && (add_o[W:W-1] == 2'b00);
            alu_req.a     = r_ff;
         end
         fds_pkg::ST_EV_D: begin
            alu_req.start = 1'b1;
            alu_req.op    = fds_pkg::ALU_DIV;
            alu_req.b     = den_eff;
         end
         fds_pkg::ST_EXP_CHK: begin
            alu_req.start = (lo_ff != fds_pkg::IDX_MAX);
            alu_req.a     = hi_calc;
            alu_req.b     = whole_ext;
         end
         fds_pkg::ST_BIN_CHK: begin
            alu_req.start = (span > W'(1));
            alu_req.a     = mid_calc;
            alu_req.b     = whole_ext;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fds_pkg::ST_IDLE;
         ret_ff       <= fds_pkg::ST_IDLE;
         evret_ff     <= fds_pkg::ST_IDLE;
         target_ff    <= 1'b0;
         whole_ff     <= '0;
         num_ff       <= '0;
         den_ff       <= 31'd1;
         started_ff   <= 1'b0;
         origin_ff    <= '0;
         next_idx_ff  <= W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == fds_pkg::ST_OUT && take_out) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         if (csr_we) begin
            unique case (fds_pkg::csr_index_type'(csr_index))
               fds_pkg::CSR_TARGET_EN: target_ff <= csr_wdata[0];
               fds_pkg::CSR_WHOLE:     whole_ff  <= csr_wdata;
               fds_pkg::CSR_NUM:       num_ff    <= csr_wdata[29:0];
               fds_pkg::CSR_DEN:       den_ff    <= csr_wdata[30:0];
               default: ;
            endcase
            started_ff  <= 1'b0;
            origin_ff   <= '0;
            next_idx_ff <= W'(1);
         end

         unique case (state_ff)
            fds_pkg::ST_IDLE: begin
               if (accept) begin
                  res_valid_ff <= 1'b0;
                  res_dl_ff    <= '0;
                  if (req_tuser[0] || !target_ff) begin
                     started_ff  <= 1'b0;
                     origin_ff   <= '0;
                     next_idx_ff <= W'(1);
                     if (req_tuser[0] && req_tuser[1]) begin
                        ret_ff   <= fds_pkg::ST_FIX_RES;
                        state_ff <= fds_pkg::ST_WAIT;
                     end else begin
                        state_ff <= fds_pkg::ST_OUT;
                     end
                  end else begin
                     if (!started_ff) begin
                        started_ff <= 1'b1;
                        origin_ff  <= req_tdata[63:0];
                     end
                     ev_idx_ff <= next_idx_ff;
                     evret_ff  <= fds_pkg::ST_MAIN_RES;
                     ret_ff    <= fds_pkg::ST_EV_A;
                     state_ff  <= fds_pkg::ST_WAIT;
                  end
               end
            end
            fds_pkg::ST_WAIT: begin
               if (alu_rsp.done) state_ff <= ret_ff;
            end
            fds_pkg::ST_FIX_RES: begin
               // product must fit below the time maximum, then app + product too
               if (alu_rsp.hi == '0 && !alu_rsp.lo[W-1] && !(!fix_sum[W] && fix_sum[W-1])) begin
                  res_valid_ff <= 1'b1;
                  res_dl_ff    <= fix_sum[W-1:0];
               end
               state_ff <= fds_pkg::ST_OUT;
            end
            fds_pkg::ST_EV_A: begin
               if (alu_req.start) begin
                  o_ff     <= alu_rsp.lo;
                  ret_ff   <= fds_pkg::ST_EV_B;
                  state_ff <= fds_pkg::ST_WAIT;
               end else begin
                  ev_ok_ff <= 1'b0;
                  state_ff <= evret_ff;
               end
            end
            fds_pkg::ST_EV_B: begin
               r_ff     <= alu_rsp.hi;
               ret_ff   <= fds_pkg::ST_EV_C;
               state_ff <= fds_pkg::ST_WAIT;
            end
            fds_pkg::ST_EV_C: begin
               if (alu_req.start) begin
                  o_ff     <= add_o[W-1:0];
                  ret_ff   <= fds_pkg::ST_EV_D;
                  state_ff <= fds_pkg::ST_WAIT;
               end else begin
                  ev_ok_ff <= 1'b0;
                  state_ff <= evret_ff;
               end
            end
            fds_pkg::ST_EV_D: begin
               ret_ff   <= fds_pkg::ST_EV_E;
               state_ff <= fds_pkg::ST_WAIT;
            end
            fds_pkg::ST_EV_E: begin
               ev_ok_ff <= (add_o[W:W-1] == 2'b00) && !(!org_sum[W] && org_sum[W-1]);
               ev_dl_ff <= org_sum[W-1:0];
               state_ff <= evret_ff;
            end
            fds_pkg::ST_MAIN_RES: begin
               if (!ev_ok_ff) begin
                  state_ff <= fds_pkg::ST_OUT;
               end else if ($signed(ev_dl_ff) <= $signed(now_ff)) begin
                  lo_ff    <= next_idx_ff;
                  hi_ff    <= next_idx_ff;
                  stp_ff   <= W'(1);
                  state_ff <= fds_pkg::ST_EXP_CHK;
               end else begin
                  res_valid_ff <= 1'b1;
                  res_dl_ff    <= ev_dl_ff;
                  if (next_idx_ff != fds_pkg::IDX_MAX) next_idx_ff <= next_idx_ff + W'(1);
                  state_ff <= fds_pkg::ST_OUT;
               end
            end
            fds_pkg::ST_EXP_CHK: begin
               if (alu_req.start) begin
                  hi_ff     <= hi_calc;
                  ev_idx_ff <= hi_calc;
                  evret_ff  <= fds_pkg::ST_EXP_RES;
                  ret_ff    <= fds_pkg::ST_EV_A;
                  state_ff  <= fds_pkg::ST_WAIT;
               end else begin
                  next_idx_ff <= lo_ff;
                  state_ff    <= fds_pkg::ST_OUT;
               end
            end
            fds_pkg::ST_EXP_RES: begin
               if (!ev_ok_ff || $signed(ev_dl_ff) > $signed(now_ff)) begin
                  state_ff <= fds_pkg::ST_BIN_CHK;
               end else begin
                  lo_ff    <= hi_ff;
                  stp_ff   <= stp_ff[W-1] ? fds_pkg::IDX_MAX : {stp_ff[W-2:0], 1'b0};
                  state_ff <= fds_pkg::ST_EXP_CHK;
               end
            end
            fds_pkg::ST_BIN_CHK: begin
               if (alu_req.start) begin
                  mid_ff    <= mid_calc;
                  ev_idx_ff <= mid_calc;
                  evret_ff  <= fds_pkg::ST_BIN_RES;
                  ret_ff    <= fds_pkg::ST_EV_A;
                  state_ff  <= fds_pkg::ST_WAIT;
               end else begin
                  next_idx_ff <= hi_ff;
                  state_ff    <= fds_pkg::ST_OUT;
               end
            end
            fds_pkg::ST_BIN_RES: begin
               if (ev_ok_ff && $signed(ev_dl_ff) <= $signed(now_ff)) lo_ff <= mid_ff;
               else hi_ff <= mid_ff;
               state_ff <= fds_pkg::ST_BIN_CHK;
            end
            fds_pkg::ST_OUT: begin
               if (take_out) begin
                  state_ff <= fds_pkg::ST_IDLE;
               end
            end
            default: state_ff <= fds_pkg::ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_tdata[127:64];
         app_ff <= req_tdata[319:256];
      end
      if (state_ff == fds_pkg::ST_OUT && take_out) begin
         rsp_flag_ff <= res_valid_ff;
         rsp_dl_ff   <= res_valid_ff ? res_dl_ff : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_dl_ff;
   assign rsp_tuser[0] = rsp_flag_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == fds_pkg::ST_WAIT)
      else $error("arith unit finished outside the wait state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != fds_pkg::ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_idx_ff != '0)
      else $error("next frame index reached zero");

endmodule
`default_nettype wire

>>> dv/tb_frame_deadline_scheduler.sv
// Self-checking testbench for the frame deadline scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_frame_deadline_scheduler;

   localparam logic [63:0] TMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] U64MX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int unsigned CYCLE_LIMIT = 200_000_000;

   typedef struct {
      bit     valid;
      longint dl;
   } deadline_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [319:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [62:0]  csr_wdata = '0;

   // shadow of the block's registers and schedule
   bit [63:0]    sh_target = 0;
   bit [63:0]    sh_whole = 0;
   bit [63:0]    sh_num = 0;
   bit [63:0]    sh_den = 1;
   bit           sched_started = 0;
   longint       sched_origin = 0;
   bit [63:0]    sched_index = 1;

   deadline_type pending_deadlines[$];
   int unsigned  mismatches = 0;
   int unsigned  cycles = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;

   frame_deadline_scheduler i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      deadline_type exp_dl;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_deadlines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected deadline: valid %0d ns %0d", rsp_tuser[0],
                        $signed(rsp_tdata));
         end else begin
            exp_dl = pending_deadlines.pop_front();
            if (rsp_tuser[0] !== exp_dl.valid || $signed(rsp_tdata) !== exp_dl.dl) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("deadline mismatch: expected valid %0d ns %0d, got valid %0d ns %0d",
                           exp_dl.valid, exp_dl.dl, rsp_tuser[0], $signed(rsp_tdata));
            end
         end
      end
   end

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit period_offset(input bit [63:0] idx, output bit [63:0] off);
      bit [63:0] den, o, cd, ro;
      den = (sh_den == 0) ? 64'd1 : sh_den;
      off = 0;
      if (idx != 0 && sh_whole > TMAX / idx) return 0;
      o  = idx * sh_whole;
      cd = idx / den;
      if (cd != 0 && sh_num > (TMAX - o) / cd) return 0;
      o  = o + cd * sh_num;
      ro = ((idx % den) * sh_num) / den;
      if (ro > TMAX - o) return 0;
      off = o + ro;
      return 1;
   endfunction

   function automatic bit frame_deadline(input bit [63:0] idx, input longint origin,
                                         output longint dl);
      bit [63:0] off;
      dl = 0;
      if (!period_offset(idx, off)) return 0;
      if (origin > longint'(TMAX) - longint'(off)) return 0;
      dl = origin + longint'(off);
      return 1;
   endfunction

   // exponential then binary search for the first index due after now
   function automatic void skip_missed_frames(input longint now);
      bit [63:0] lo, hi, stride, mid;
      longint    dl;
      lo = sched_index; hi = lo; stride = 1;
      while (hi != U64MX) begin
         hi = (stride > U64MX - lo) ? U64MX : lo + stride;
         if (!frame_deadline(hi, sched_origin, dl) || dl > now) break;
         lo = hi;
         stride = (stride > U64MX / 2) ? U64MX : stride * 2;
      end
      if (hi == lo) begin
         sched_index = hi;
         return;
      end
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         if (frame_deadline(mid, sched_origin, dl) && dl <= now) lo = mid;
         else hi = mid;
      end
      sched_index = hi;
   endfunction

   function automatic void sched_clear();
      sched_started = 0;
      sched_origin = 0;
      sched_index = 1;
   endfunction

   function automatic void predict_deadline(input longint fs, input longint now,
      input bit fixed, input bit [63:0] step, input bit pace, input bit [63:0] frames,
      input longint app);
      deadline_type r;
      longint el;
      r.valid = 0; r.dl = 0;
      if (fixed) begin
         sched_clear();
         if (pace && !(frames != 0 && step > TMAX / frames)) begin
            el = longint'(step * frames);
            if (app <= longint'(TMAX) - el) begin
               r.valid = 1;
               r.dl = app + el;
            end
         end
      end else if (sh_target == 0) begin
         sched_clear();
      end else begin
         if (!sched_started) begin
            sched_started = 1;
            sched_origin = fs;
         end
         if (frame_deadline(sched_index, sched_origin, r.dl)) begin
            if (r.dl <= now) begin
               skip_missed_frames(now);
            end else begin
               r.valid = 1;
               if (sched_index != U64MX) sched_index++;
            end
         end
         if (!r.valid) r.dl = 0;
      end
      pending_deadlines.push_back(r);
   endfunction

   // drop the last request off the bus before waiting, or it is taken again
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_deadlines.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input fds_pkg::csr_index_type idx, input bit [62:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         fds_pkg::CSR_TARGET_EN: sh_target = value & 64'h1;
         fds_pkg::CSR_WHOLE:     sh_whole  = value & 64'h7FFF_FFFF_FFFF_FFFF;
         fds_pkg::CSR_NUM:       sh_num    = value & 64'h3FFF_FFFF;
         fds_pkg::CSR_DEN:       sh_den    = value & 64'h7FFF_FFFF;
      endcase
      sched_clear();
   endtask

   task automatic set_period(input bit en, input bit [62:0] whole, input bit [62:0] num,
                             input bit [62:0] den);
      write_csr(fds_pkg::CSR_WHOLE, whole);
      write_csr(fds_pkg::CSR_NUM, num);
      write_csr(fds_pkg::CSR_DEN, den);
      write_csr(fds_pkg::CSR_TARGET_EN, en);
   endtask

   task automatic send_frame(input longint fs, input longint now, input bit fixed,
      input bit [63:0] step, input bit pace, input bit [63:0] frames, input longint app);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {app, frames, step, now, fs};
      req_tuser <= {pace, fixed};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_deadline(fs, now, fixed, step, pace, frames, app);
   endtask

   // target-mode request with now placed near the next deadline
   task automatic send_paced_frame(input longint fs);
      longint    origin, dl, now;
      bit [63:0] span;
      origin = sched_started ? sched_origin : fs;
      span = (sh_whole > 64'd100000) ? 64'd100000 : sh_whole + 3;
      if (frame_deadline(sched_index, origin, dl)) begin
         if ($urandom_range(0, 9) < 7)
            now = dl - longint'($urandom_range(1, 2000));
         else
            now = dl + longint'($urandom_range(0, 3 * int'(span)));
      end else begin
         now = fs + longint'($urandom_range(0, 1000));
      end
      send_frame(fs, now, 1'b0, rand64(), $urandom_range(0, 1), rand64(), rand64());
   endtask

   task automatic random_frame(input longint base);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         send_frame(rand64(), rand64(), 1'b1, rand64(), $urandom_range(0, 1), rand64(),
                    rand64());
      end else if (pick < 6) begin
         send_frame(rand64(), rand64(), $urandom_range(0, 1), rand64(),
                    $urandom_range(0, 1), rand64(), rand64());
      end else if (pick < 30) begin
         send_frame(rand64(), rand64(), 1'b1, {32'd0, $urandom}, $urandom_range(0, 1),
                    $urandom_range(0, 100000), longint'($signed($urandom)));
      end else begin
         send_paced_frame(base + longint'($urandom_range(0, 1000)));
      end
   endtask

   task automatic test_no_target();
      send_frame(0, 0, 1'b0, 0, 1'b0, 0, 0);
      send_frame(-64'sd1, 64'sd5, 1'b0, U64MX, 1'b1, U64MX, -64'sd1);
      send_frame(longint'(TMAX), longint'(TMAX), 1'b1, 64'd10, 1'b0, 64'd3, 64'sd7);
   endtask

   task automatic test_fixed_step();
      send_frame(0, 0, 1'b1, 64'd16_666_667, 1'b1, 64'd10, 64'sd1000);
      send_frame(0, 0, 1'b1, U64MX, 1'b1, 64'd0, -64'sd9);
      send_frame(0, 0, 1'b1, TMAX, 1'b1, 64'd1, 64'sd0);
      send_frame(0, 0, 1'b1, TMAX, 1'b1, 64'd1, 64'sd1);          // sum overflows
      send_frame(0, 0, 1'b1, TMAX, 1'b1, 64'd2, -64'sd100);       // product overflows
      send_frame(0, 0, 1'b1, 64'd1, 1'b1, U64MX, 64'sd0);
      send_frame(0, 0, 1'b1, 64'd0, 1'b1, U64MX, longint'(TMAX));
      send_frame(0, 0, 1'b1, 64'd5, 1'b1, 64'd5, longint'(64'h8000_0000_0000_0000));
   endtask

   task automatic test_target_schedule();
      set_period(1'b1, 63'd1000, 63'd1, 63'd3);
      send_frame(64'sd5000, 64'sd5000, 1'b0, 0, 1'b0, 0, 0);
      send_frame(64'sd0, 64'sd5500, 1'b0, 0, 1'b0, 0, 0);
      send_frame(64'sd0, 64'sd20000, 1'b0, 0, 1'b0, 0, 0);        // missed, skip ahead
      send_frame(64'sd0, 64'sd20000, 1'b0, 0, 1'b0, 0, 0);
      send_frame(64'sd0, 64'sd0, 1'b1, 0, 1'b0, 0, 0);            // fixed step resets
      send_frame(-64'sd77, -64'sd100, 1'b0, 0, 1'b0, 0, 0);
      // zero denominator, numerator above denominator
      set_period(1'b1, 63'd10, 63'h3FFF_FFFF, 63'd0);
      send_frame(64'sd0, 64'sd0, 1'b0, 0, 1'b0, 0, 0);
      set_period(1'b1, 63'd10, 63'd7, 63'h7FFF_FFFF);
      send_frame(64'sd0, 64'sd0, 1'b0, 0, 1'b0, 0, 0);
      send_frame(64'sd0, 64'sd1, 1'b0, 0, 1'b0, 0, 0);
      // whole period at the maximum overflows every index above 1
      set_period(1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 63'd0, 63'd1);
      send_frame(longint'(64'h8000_0000_0000_0000), 64'sd0, 1'b0, 0, 1'b0, 0, 0);
      // deadline at the top of the time range, then just past it
      set_period(1'b1, 63'd100, 63'd0, 63'd1);
      send_frame(longint'(TMAX) - 64'sd100, 64'sd0, 1'b0, 0, 1'b0, 0, 0);
      send_frame(0, 64'sd0, 1'b0, 0, 1'b0, 0, 0);
      // zero period: a miss drives the index to saturation
      set_period(1'b1, 63'd0, 63'd0, 63'd1);
      send_frame(64'sd50, 64'sd60, 1'b0, 0, 1'b0, 0, 0);
      send_frame(64'sd0, 64'sd10, 1'b0, 0, 1'b0, 0, 0);
      send_frame(64'sd0, 64'sd10, 1'b0, 0, 1'b0, 0, 0);
   endtask

   task automatic set_random_period();
      bit [62:0] den;
      den = ($urandom_range(0, 9) == 0) ? 63'd0 : 63'($urandom_range(1, 1 << 30));
      set_period($urandom_range(0, 7) != 0, 63'($urandom_range(0, 100000)),
                 63'($urandom_range(0, 1 << 30)) & 63'h3FFF_FFFF, den);
   endtask

   task automatic test_random_traffic(input int n, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      longint base;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            set_random_period();
            base = longint'($signed(rand64())) >>> 2;
         end
         if (i % 97 == 50) wait_drained();   // let the pipe empty now and then
         random_frame(base);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 13;
      rsp_stall_pct = 86;
      test_no_target();
      test_fixed_step();
      test_target_schedule();
      test_random_traffic(280, 13, 86);
      test_random_traffic(280, 86, 13);
      test_random_traffic(280, 0, 0);
      wait_drained();
      repeat (500) @(posedge clock);
      if (mismatches == 0 && pending_deadlines.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
